[src/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// Types and constants shared by the WAV stream parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

   typedef enum logic [6:0] {
      PH_RIFF  = 7'b0000001,
      PH_CHUNK = 7'b0000010,
      PH_FMT   = 7'b0000100,
      PH_SKIP  = 7'b0001000,
      PH_AUDIO = 7'b0010000,
      PH_DONE  = 7'b0100000,
      PH_ERROR = 7'b1000000
   } wsp_phase_type;

   localparam logic [2:0] ST_FRAME       = 3'd0;
   localparam logic [2:0] ST_END_OK      = 3'd1;
   localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
   localparam logic [2:0] ST_FMT_LARGE   = 3'd3;
   localparam logic [2:0] ST_FMT_SMALL   = 3'd4;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
   localparam logic [2:0] ST_INCOMPLETE  = 3'd6;

   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] PCM_FORMAT    = 16'd1;
   localparam logic [15:0] STEREO_COUNT  = 16'd2;
   localparam logic [15:0] SAMPLE_DEPTH  = 16'd16;
   localparam logic [31:0] DEFAULT_RATE  = 32'd44100;

   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic        last_frame;
      logic [1:0]  discarded_bytes;
   } wsp_result_type;

   function automatic logic [7:0] riff_expect(input logic [3:0] idx);
      logic [7:0] value;
      case (idx)
         4'd0:    value = 8'h52;
         4'd1:    value = 8'h49;
         4'd2:    value = 8'h46;
         4'd3:    value = 8'h46;
         4'd8:    value = 8'h57;
         4'd9:    value = 8'h41;
         4'd10:   value = 8'h56;
         4'd11:   value = 8'h45;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

[src/wsp_parse_core.sv]
// ----------------------------------------------------------------------------
// wsp_parse_core
// Parser state and the per-byte update; gives the result of the current item.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_parse_core #(
   parameter int FMT_BUFFER_BYTES = 512
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  mode,
   input  wire logic [7:0]            data_byte,
   input  wire logic [31:0]           expected_rate,
   output wsp_pkg::wsp_result_type    result
);
   import wsp_pkg::*;

   localparam int CountWidth = $clog2(FMT_BUFFER_BYTES + 1);
   localparam logic [CountWidth-1:0] FmtLimit = CountWidth'(FMT_BUFFER_BYTES);
   localparam logic [CountWidth-1:0] FmtMin   = CountWidth'(16);
   localparam logic [CountWidth-1:0] FmtLast  = CountWidth'(15);
   localparam logic [CountWidth-1:0] RiffLast = CountWidth'(11);
   localparam logic [CountWidth-1:0] ChunkLast = CountWidth'(7);

   wsp_phase_type         phase_ff, phase_in;
   logic [CountWidth-1:0] header_count_ff, header_count_in;
   logic                  riff_mismatch_ff, riff_mismatch_in;
   logic [31:0]           chunk_tag_ff, chunk_tag_in;
   logic [31:0]           chunk_left_ff, chunk_left_in;
   logic [15:0]           format_code_ff, format_code_in;
   logic [15:0]           channel_total_ff, channel_total_in;
   logic [31:0]           rate_seen_ff, rate_seen_in;
   logic [15:0]           sample_bits_ff, sample_bits_in;
   logic                  format_seen_ff, format_seen_in;
   logic                  data_seen_ff, data_seen_in;
   logic [23:0]           partial_frame_ff, partial_frame_in;
   logic [1:0]            partial_count_ff, partial_count_in;
   logic [2:0]            err_code_ff, err_code_in;

   logic [7:0] expect_byte;
   logic       mismatch;
   logic       raise;
   logic [2:0] raise_code;

   assign expect_byte = riff_expect(header_count_ff[3:0]);
   assign mismatch = riff_mismatch_ff | ((expect_byte != 8'h00) && (expect_byte != data_byte));

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      riff_mismatch_in = riff_mismatch_ff;
      chunk_tag_in     = chunk_tag_ff;
      chunk_left_in    = chunk_left_ff;
      format_code_in   = format_code_ff;
      channel_total_in = channel_total_ff;
      rate_seen_in     = rate_seen_ff;
      sample_bits_in   = sample_bits_ff;
      format_seen_in   = format_seen_ff;
      data_seen_in     = data_seen_ff;
      partial_frame_in = partial_frame_ff;
      partial_count_in = partial_count_ff;
      err_code_in      = err_code_ff;
      result           = '0;
      raise            = 1'b0;
      raise_code       = ST_INCOMPLETE;

      if (accept) begin
         if (mode) begin
            if (phase_ff == PH_ERROR) begin
               result.valid  = 1'b1;
               result.status = err_code_ff;
            end else if (!format_seen_ff || !data_seen_ff) begin
               raise      = 1'b1;
               raise_code = ST_INCOMPLETE;
            end else begin
               result.valid           = 1'b1;
               result.status          = ST_END_OK;
               result.discarded_bytes = partial_count_ff;
               partial_count_in       = 2'd0;
               partial_frame_in       = 24'd0;
               phase_in               = PH_DONE;
            end
         end else begin
            case (phase_ff)
               PH_RIFF: begin
                  riff_mismatch_in = mismatch;
                  header_count_in  = header_count_ff + 1'b1;
                  if (header_count_ff == RiffLast) begin
                     if (mismatch) begin
                        raise      = 1'b1;
                        raise_code = ST_NOT_WAVE;
                     end else begin
                        header_count_in = '0;
                        phase_in        = PH_CHUNK;
                     end
                  end
               end
               PH_CHUNK: begin
                  if (!header_count_ff[2]) begin
                     chunk_tag_in[{header_count_ff[1:0], 3'b000} +: 8] = data_byte;
                  end else begin
                     chunk_left_in[{header_count_ff[1:0], 3'b000} +: 8] = data_byte;
                  end
                  header_count_in = header_count_ff + 1'b1;
                  if (header_count_ff == ChunkLast) begin
                     header_count_in = '0;
                     if (chunk_tag_in == TAG_FMT) begin
                        phase_in = PH_FMT;
                     end else if (chunk_tag_in == TAG_DATA) begin
                        if ((format_code_ff != PCM_FORMAT) ||
                            (channel_total_ff != STEREO_COUNT) ||
                            (rate_seen_ff != expected_rate) ||
                            (sample_bits_ff != SAMPLE_DEPTH)) begin
                           raise      = 1'b1;
                           raise_code = ST_UNSUPPORTED;
                        end else begin
                           data_seen_in = 1'b1;
                           phase_in = (chunk_left_in == 32'd0) ? PH_DONE : PH_AUDIO;
                        end
                     end else begin
                        phase_in = (chunk_left_in == 32'd0) ? PH_CHUNK : PH_SKIP;
                     end
                  end
               end
               PH_FMT: begin
                  if (chunk_left_ff == 32'd0) begin
                     raise      = 1'b1;
                     raise_code = ST_FMT_SMALL;
                  end else if (header_count_ff >= FmtLimit) begin
                     raise      = 1'b1;
                     raise_code = ST_FMT_LARGE;
                  end else begin
                     if (header_count_ff < FmtMin) begin
                        case (header_count_ff[3:0])
                           4'd0:    format_code_in[7:0]    = data_byte;
                           4'd1:    format_code_in[15:8]   = data_byte;
                           4'd2:    channel_total_in[7:0]  = data_byte;
                           4'd3:    channel_total_in[15:8] = data_byte;
                           4'd4:    rate_seen_in[7:0]      = data_byte;
                           4'd5:    rate_seen_in[15:8]     = data_byte;
                           4'd6:    rate_seen_in[23:16]    = data_byte;
                           4'd7:    rate_seen_in[31:24]    = data_byte;
                           4'd14:   sample_bits_in[7:0]    = data_byte;
                           4'd15:   sample_bits_in[15:8]   = data_byte;
                           default: ;
                        endcase
                     end
                     header_count_in = header_count_ff + 1'b1;
                     chunk_left_in   = chunk_left_ff - 32'd1;
                     if (chunk_left_ff == 32'd1) begin
                        if (header_count_ff < FmtLast) begin
                           raise      = 1'b1;
                           raise_code = ST_FMT_SMALL;
                        end else begin
                           format_seen_in  = 1'b1;
                           header_count_in = '0;
                           phase_in        = PH_CHUNK;
                        end
                     end
                  end
               end
               PH_SKIP: begin
                  chunk_left_in = chunk_left_ff - 32'd1;
                  if (chunk_left_ff == 32'd1) begin
                     phase_in = PH_CHUNK;
                  end
               end
               PH_AUDIO: begin
                  chunk_left_in = chunk_left_ff - 32'd1;
                  if (partial_count_ff != 2'd3) begin
                     partial_frame_in[{partial_count_ff, 3'b000} +: 8] = data_byte;
                     partial_count_in = partial_count_ff + 2'd1;
                  end else begin
                     result.valid        = 1'b1;
                     result.status       = ST_FRAME;
                     result.left_sample  = partial_frame_ff[15:0];
                     result.right_sample = {data_byte, partial_frame_ff[23:16]};
                     result.last_frame   = (chunk_left_ff == 32'd1);
                     partial_frame_in    = 24'd0;
                     partial_count_in    = 2'd0;
                  end
                  if (chunk_left_ff == 32'd1) begin
                     phase_in = PH_DONE;
                  end
               end
               default: ;
            endcase
         end

         if (raise) begin
            phase_in      = PH_ERROR;
            err_code_in   = raise_code;
            result        = '0;
            result.valid  = 1'b1;
            result.status = raise_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_RIFF;
         header_count_ff  <= '0;
         riff_mismatch_ff <= 1'b0;
         chunk_tag_ff     <= 32'd0;
         chunk_left_ff    <= 32'd0;
         format_code_ff   <= 16'd0;
         channel_total_ff <= 16'd0;
         rate_seen_ff     <= 32'd0;
         sample_bits_ff   <= 16'd0;
         format_seen_ff   <= 1'b0;
         data_seen_ff     <= 1'b0;
         partial_frame_ff <= 24'd0;
         partial_count_ff <= 2'd0;
         err_code_ff      <= 3'd0;
      end else begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         riff_mismatch_ff <= riff_mismatch_in;
         chunk_tag_ff     <= chunk_tag_in;
         chunk_left_ff    <= chunk_left_in;
         format_code_ff   <= format_code_in;
         channel_total_ff <= channel_total_in;
         rate_seen_ff     <= rate_seen_in;
         sample_bits_ff   <= sample_bits_in;
         format_seen_ff   <= format_seen_in;
         data_seen_ff     <= data_seen_in;
         partial_frame_ff <= partial_frame_in;
         partial_count_ff <= partial_count_in;
         err_code_ff      <= err_code_in;
      end
   end

endmodule

`default_nettype wire

[src/wav_stream_parser.sv]
// A result item appears in the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle while req_stall is low; the parser state updates in a single pass per byte.
// req_stall is high only while the output register holds an item and rsp_stall is high.
// Reset (synchronous): parser returns to the RIFF header phase, all captured fields and
// the sticky error clear, the output register empties, the rate register returns to 44100.
// ----------------------------------------------------------------------------
// wav_stream_parser
// Byte-serial RIFF/WAVE PCM parser giving 16-bit stereo frames and status items.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_parser #(
   parameter int FMT_BUFFER_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic             rsp_last_frame,
   output logic [1:0]       rsp_discarded_bytes
);
   import wsp_pkg::*;

   logic [31:0]    expected_rate_ff;
   logic           rsp_valid_ff;
   wsp_result_type rsp_data_ff;
   wsp_result_type result;
   logic           req_accept;
   logic           out_load;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign out_load   = !rsp_valid_ff || !rsp_stall;

   wsp_parse_core #(
      .FMT_BUFFER_BYTES(FMT_BUFFER_BYTES)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .mode         (req_mode),
      .data_byte    (req_data_byte),
      .expected_rate(expected_rate_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_rate_ff <= DEFAULT_RATE;
      end else if (csr_wr_en) begin
         expected_rate_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_data_ff.status;
   assign rsp_left_sample     = rsp_data_ff.left_sample;
   assign rsp_right_sample    = rsp_data_ff.right_sample;
   assign rsp_last_frame      = rsp_data_ff.last_frame;
   assign rsp_discarded_bytes = rsp_data_ff.discarded_bytes;

endmodule

`default_nettype wire

[src/wsp_checker.sv]
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks on the WAV stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [15:0] rsp_left_sample,
   input wire logic [15:0] rsp_right_sample,
   input wire logic        rsp_last_frame,
   input wire logic [1:0]  rsp_discarded_bytes
);
   import wsp_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_status_zero_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_FRAME)) |->
         ((rsp_left_sample == 16'd0) && (rsp_right_sample == 16'd0) && !rsp_last_frame))
      else $error("non-frame item carries sample data");

   a_discard_only_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_discarded_bytes != 2'd0)) |-> (rsp_status == ST_END_OK))
      else $error("discarded count outside end of stream");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_left_sample) && $stable(rsp_right_sample)))
      else $error("stalled result changed");

endmodule

bind wav_stream_parser wsp_checker u_wsp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_left_sample    (rsp_left_sample),
   .rsp_right_sample   (rsp_right_sample),
   .rsp_last_frame     (rsp_last_frame),
   .rsp_discarded_bytes(rsp_discarded_bytes)
);

`default_nettype wire
